// ===== hw/rtl/sbtr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbtr_pkg: shared types and constants for the scaled bitmap text renderer
// Field widths, command encoding, register indexes and the row expander.
// ----------------------------------------------------------------------------
package sbtr_pkg;

  // Font geometry
  localparam int GLYPH_ROWS  = 5;
  localparam int GLYPH_COUNT = 256;
  localparam int MAX_SCALE   = 8;
  localparam int ROW_BITS    = 8;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;

  // Field widths fixed by the interface
  localparam int MODE_W  = 2;
  localparam int CODE_W  = 8;
  localparam int ADDR_W  = 11;
  localparam int DATA_W  = 8;
  localparam int COORD_W = 16;
  localparam int SCALE_W = 4;
  localparam int ADV_W   = 8;
  localparam int COLOR_W = 32;
  localparam int MASK_W  = 64;
  localparam int SPAN_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Derived counter widths
  localparam int GLYPH_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ROW_W   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int REP_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  // Command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_DRAW = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FONT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOME = 2'd2;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] char_code;
    logic [ADDR_W-1:0] font_addr;
    logic [DATA_W-1:0] font_data;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_pos;
    logic [MASK_W-1:0]  pixel_mask;
    logic [SPAN_W-1:0]  span_width;
    logic [COLOR_W-1:0] color;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [ADV_W-1:0]   advance_x;
    logic [ADV_W-1:0]   advance_y;
    logic [COLOR_W-1:0] ink_color;
  } cfg_t;

  // Classified command passed from front end to back end
  typedef enum logic [1:0] {
    OP_DRAW,
    OP_FONT,
    OP_HOME,
    OP_NEWLINE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;   // glyph base for draw, store address for font
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Clamp a scale register to 1 .. MAX_SCALE
  function automatic logic [SCALE_W-1:0] eff_scale(logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    if (s == '0) begin
      r = SCALE_W'(1);
    end else if (s > SCALE_W'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Repeat each source bit xs times, bit 7 lands at mask bit 0
  function automatic logic [MASK_W-1:0] expand_row(logic [DATA_W-1:0] bits,
                                                   logic [SCALE_W-1:0] xs);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int s = 1; s <= MAX_SCALE; s++) begin
      if (xs == SCALE_W'(s)) begin
        for (int i = 0; i < ROW_BITS; i++) begin
          for (int j = 0; j < s; j++) begin
            m[i*s+j] = bits[ROW_BITS-1-i];
          end
        end
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sbtr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbtr_front: input stage
// Accepts input transactions, drops the ones without effect and turns the
// rest into draw, font, home or newline commands for the queue.
// ----------------------------------------------------------------------------
module sbtr_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sbtr_pkg::in_item_t  in_data,
  output logic                cmd_valid,
  input  wire                 cmd_ready,
  output sbtr_pkg::cmd_t      cmd_data
);

  logic           valid_r, valid_nxt;
  sbtr_pkg::cmd_t cmd_r, cmd_nxt;
  logic           keep;
  logic           accept;

  // Classify the incoming transaction
  always_comb begin
    keep             = 1'b0;
    cmd_nxt.op       = sbtr_pkg::OP_DRAW;
    cmd_nxt.addr     = sbtr_pkg::ADDR_W'(
                         in_data.char_code[sbtr_pkg::GLYPH_W-1:0] * sbtr_pkg::GLYPH_ROWS);
    cmd_nxt.data     = in_data.font_data;
    case (in_data.mode)
      sbtr_pkg::MODE_DRAW: begin
        keep = 1'b1;
        if (in_data.char_code == sbtr_pkg::NEWLINE_CODE) begin
          cmd_nxt.op = sbtr_pkg::OP_NEWLINE;
        end
      end
      sbtr_pkg::MODE_FONT: begin
        cmd_nxt.op   = sbtr_pkg::OP_FONT;
        cmd_nxt.addr = in_data.font_addr;
        keep         = in_data.font_addr < sbtr_pkg::ADDR_W'(sbtr_pkg::STORE_DEPTH);
      end
      sbtr_pkg::MODE_HOME: begin
        cmd_nxt.op = sbtr_pkg::OP_HOME;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // Hold one command until the queue takes it
  assign in_ready  = !valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = keep;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbtr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbtr_queue: command queue
// Small FIFO between the input stage and the render engine.
// ----------------------------------------------------------------------------
module sbtr_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  sbtr_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  wire             pop_ready,
  output sbtr_pkg::cmd_t  pop_data
);

  localparam int CNT_W = $clog2(sbtr_pkg::QUEUE_DEPTH + 1);

  sbtr_pkg::cmd_t                entry_r [sbtr_pkg::QUEUE_DEPTH];
  logic [sbtr_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sbtr_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          do_push, do_pop;

  assign push_ready = count_r != CNT_W'(sbtr_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sbtr_pkg::QPTR_W'(sbtr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sbtr_pkg::QPTR_W'(sbtr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbtr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbtr_back: render engine
// Owns the glyph store and the cursor, executes queued commands and walks
// the glyph rows of a draw command, one span per cycle when not stalled.
// ----------------------------------------------------------------------------
module sbtr_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sbtr_pkg::cfg_t      cfg,
  input  wire                 cmd_valid,
  output logic                cmd_ready,
  input  sbtr_pkg::cmd_t      cmd_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output sbtr_pkg::out_item_t out_data
);

  logic [sbtr_pkg::DATA_W-1:0]  glyph_mem [sbtr_pkg::STORE_DEPTH];
  logic [sbtr_pkg::DATA_W-1:0]  rd_data_r;

  sbtr_pkg::state_t             state_r, state_nxt;
  logic [sbtr_pkg::ADDR_W-1:0]  base_r;
  logic [sbtr_pkg::ROW_W-1:0]   row_r;
  logic [sbtr_pkg::REP_W-1:0]   rep_r;
  logic [sbtr_pkg::COORD_W-1:0] ypos_r;
  logic [sbtr_pkg::COORD_W-1:0] cursor_x_r, cursor_y_r;
  logic                         out_valid_r;
  sbtr_pkg::out_item_t          out_r;

  logic [sbtr_pkg::SCALE_W-1:0] xs, ys;
  logic [sbtr_pkg::REP_W-1:0]   rep_max;
  logic                         rep_end, row_end;
  logic                         cmd_pop, start_draw;
  logic                         emit, out_free;
  logic                         rd_en;
  logic [sbtr_pkg::ADDR_W-1:0]  rd_addr;

  assign xs      = sbtr_pkg::eff_scale(cfg.x_scale);
  assign ys      = sbtr_pkg::eff_scale(cfg.y_scale);
  assign rep_max = sbtr_pkg::REP_W'(ys - 1'b1);
  assign rep_end = rep_r == rep_max;
  assign row_end = row_r == sbtr_pkg::ROW_W'(sbtr_pkg::GLYPH_ROWS - 1);
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbtr_pkg::ST_IDLE: begin
        if (cmd_valid && cmd_data.op == sbtr_pkg::OP_DRAW) begin
          state_nxt = sbtr_pkg::ST_EMIT;
        end
      end
      sbtr_pkg::ST_EMIT: begin
        if (out_free && rep_end && row_end) begin
          state_nxt = sbtr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbtr_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: pop, span emit, glyph row fetch
  always_comb begin
    cmd_pop    = 1'b0;
    start_draw = 1'b0;
    emit       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cmd_data.addr;
    case (state_r)
      sbtr_pkg::ST_IDLE: begin
        cmd_pop    = cmd_valid;
        start_draw = cmd_valid && cmd_data.op == sbtr_pkg::OP_DRAW;
        rd_en      = start_draw;
      end
      sbtr_pkg::ST_EMIT: begin
        emit    = out_free;
        rd_en   = out_free && rep_end && !row_end;
        rd_addr = base_r + sbtr_pkg::ADDR_W'(row_r) + 1'b1;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  assign cmd_ready = cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbtr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Glyph store: font writes and row reads share the single port schedule
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_data.op == sbtr_pkg::OP_FONT) begin
      glyph_mem[cmd_data.addr] <= cmd_data.data;
    end
    if (rd_en) begin
      rd_data_r <= glyph_mem[rd_addr];
    end
  end

  // Cursor updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
    end else if (cmd_pop && cmd_data.op == sbtr_pkg::OP_HOME) begin
      cursor_x_r <= cfg.origin_x;
      cursor_y_r <= cfg.origin_y;
    end else if (cmd_pop && cmd_data.op == sbtr_pkg::OP_NEWLINE) begin
      cursor_x_r <= cfg.origin_x;
      cursor_y_r <= cursor_y_r + sbtr_pkg::COORD_W'(cfg.advance_y);
    end else if (emit && rep_end && row_end) begin
      cursor_x_r <= cursor_x_r + sbtr_pkg::COORD_W'(cfg.advance_x);
    end
  end

  // Row and repeat counters
  always_ff @(posedge clk) begin
    if (start_draw) begin
      base_r <= cmd_data.addr;
      row_r  <= '0;
      rep_r  <= '0;
      ypos_r <= cursor_y_r;
    end else if (emit) begin
      ypos_r <= ypos_r + 1'b1;
      if (rep_end) begin
        rep_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        rep_r <= rep_r + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.x_start    <= cursor_x_r;
      out_r.y_pos      <= ypos_r;
      out_r.pixel_mask <= sbtr_pkg::expand_row(rd_data_r, xs);
      out_r.span_width <= {xs[sbtr_pkg::SPAN_W-4:0], 3'b000};
      out_r.color      <= cfg.ink_color;
      out_r.last       <= rep_end && row_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Commands are taken only between characters
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> state_r == sbtr_pkg::ST_IDLE)
    else $error("command popped during a draw");

  // The final span of a character returns the engine to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && rep_end && row_end) |=> state_r == sbtr_pkg::ST_IDLE)
    else $error("engine still busy after final span");

  // Counters stay inside the glyph while drawing
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sbtr_pkg::ST_EMIT |->
      (row_r <= sbtr_pkg::ROW_W'(sbtr_pkg::GLYPH_ROWS - 1) && rep_r <= rep_max))
    else $error("row or repeat counter out of range");

  // A new row is fetched only as the previous row completes
  assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && state_r == sbtr_pkg::ST_EMIT) |-> (emit && rep_end))
    else $error("glyph row fetched mid row");

endmodule
`default_nettype wire

// ===== hw/rtl/scaled_bitmap_text_renderer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_bitmap_text_renderer: 5x8 bitmap font character generator
// Register file, input stage, command queue and render engine.
// ----------------------------------------------------------------------------
// A character is drawn as 5 * y_scale spans, with y_scale taken as 1 when it
// is zero and as 8 when it is above 8; one span leaves per cycle when the
// result side does not stall, paced by the row sequencer in the engine,
// which reads one glyph row per row from the single port of the glyph store.
// Font writes, home and newline are executed by the engine but give no
// results; mode 3 and font writes beyond the store are dropped at the input.
// A four-entry command queue lets input transactions be taken while a
// character is still being drawn. The glyph store has no reset and no
// clearing pass: an entry must be written before a character that uses it is
// drawn. Registers may be written only while the block is idle; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module scaled_bitmap_text_renderer (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  sbtr_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output sbtr_pkg::out_item_t                  out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [sbtr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [sbtr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  sbtr_pkg::cfg_t cfg_r;
  logic           f_valid, f_ready;
  sbtr_pkg::cmd_t f_cmd;
  logic           q_valid, q_ready;
  sbtr_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x  <= '0;
      cfg_r.origin_y  <= '0;
      cfg_r.x_scale   <= sbtr_pkg::SCALE_W'(1);
      cfg_r.y_scale   <= sbtr_pkg::SCALE_W'(1);
      cfg_r.advance_x <= sbtr_pkg::ADV_W'(6);
      cfg_r.advance_y <= sbtr_pkg::ADV_W'(6);
      cfg_r.ink_color <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbtr_pkg::REG_ORIGIN_X:  cfg_r.origin_x  <= cfg_data[sbtr_pkg::COORD_W-1:0];
        sbtr_pkg::REG_ORIGIN_Y:  cfg_r.origin_y  <= cfg_data[sbtr_pkg::COORD_W-1:0];
        sbtr_pkg::REG_X_SCALE:   cfg_r.x_scale   <= cfg_data[sbtr_pkg::SCALE_W-1:0];
        sbtr_pkg::REG_Y_SCALE:   cfg_r.y_scale   <= cfg_data[sbtr_pkg::SCALE_W-1:0];
        sbtr_pkg::REG_ADVANCE_X: cfg_r.advance_x <= cfg_data[sbtr_pkg::ADV_W-1:0];
        sbtr_pkg::REG_ADVANCE_Y: cfg_r.advance_y <= cfg_data[sbtr_pkg::ADV_W-1:0];
        sbtr_pkg::REG_INK_COLOR: cfg_r.ink_color <= cfg_data[sbtr_pkg::COLOR_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  sbtr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  sbtr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  sbtr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
